// ===== rtl/tfa_pkg.sv =====
// Shared types and constants for the thruster force allocation block.
`default_nettype none

package tfa_pkg;

    localparam int MAX_THRUSTERS = 8;
    localparam int AXES          = 6;
    localparam int QUEUE_DEPTH   = 2;
    localparam int DATA_W        = 16;
    localparam int FORCE_W       = 32;
    localparam int SUM_W         = 40;
    localparam int MODE_W        = 3;
    localparam int MODE_SEL_W    = $clog2(MAX_THRUSTERS);

    // register file
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_THRUSTER_COUNT = 2'd0;
    localparam reg_index_t REG_MODE_MAP       = 2'd1;
    localparam reg_index_t REG_SUPPLY_VOLTAGE = 2'd2;
    localparam reg_index_t REG_DEAD_BAND      = 2'd3;

    localparam logic [3:0]  THRUSTER_COUNT_RST = 4'd6;
    localparam logic [23:0] MODE_MAP_RST       = 24'd4793490;
    localparam logic [15:0] SUPPLY_VOLTAGE_RST = 16'd256;
    localparam logic [7:0]  DEAD_BAND_RST      = 8'd3;

    // per-thruster mode codes; position and above are unsupported
    typedef logic [MODE_W-1:0] mode_code_t;
    localparam mode_code_t MODE_EFFORT   = 3'd0;
    localparam mode_code_t MODE_SPEED    = 3'd1;
    localparam mode_code_t MODE_RAW      = 3'd2;
    localparam mode_code_t MODE_POSITION = 3'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_COUNT = 2'd1;
    localparam status_t STATUS_UNSET = 2'd2;
    localparam status_t STATUS_MODE  = 2'd3;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_EFFORT,
        KIND_QUAD
    } kind_t;

    // one classified thruster beat
    typedef struct packed {
        kind_t                         kind;
        logic                          raw;
        logic signed [DATA_W-1:0]      cmd;
        logic signed [DATA_W-1:0]      coeff;
        logic [AXES-1:0][DATA_W-1:0]   col;
        logic                          last;
        status_t                       status;
    } tfa_entry_t;

    typedef struct packed {
        logic       valid;
        tfa_entry_t entry;
    } tfa_head_t;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_SCALE,
        BE_CHECK,
        BE_SQUARE,
        BE_MUL_LO,
        BE_MUL_HI,
        BE_SAT,
        BE_AXIS_MUL,
        BE_AXIS_ACC
    } be_state_t;

endpackage

`default_nettype wire

// ===== rtl/tfa_front.sv =====
// Front end: accepts thruster beats, picks the mode, tracks sample position and status.
`default_nettype none

module tfa_front
    import tfa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    input  wire logic                     q_full,
    input  wire logic signed [DATA_W-1:0] command_value,
    input  wire logic                     value_present,
    input  wire logic signed [DATA_W-1:0] coeff_positive,
    input  wire logic signed [DATA_W-1:0] coeff_negative,
    input  wire logic signed [DATA_W-1:0] col_surge,
    input  wire logic signed [DATA_W-1:0] col_sway,
    input  wire logic signed [DATA_W-1:0] col_heave,
    input  wire logic signed [DATA_W-1:0] col_roll,
    input  wire logic signed [DATA_W-1:0] col_pitch,
    input  wire logic signed [DATA_W-1:0] col_yaw,
    input  wire logic                     last_thruster,
    input  wire logic [3:0]               thruster_count,
    input  wire logic [MODE_W*MAX_THRUSTERS-1:0] mode_map,
    output logic                          push,
    output tfa_entry_t                    push_entry
);

    logic [3:0] position_reg, position_next;
    status_t    pending_reg, pending_next;

    mode_code_t modes [MAX_THRUSTERS];
    mode_code_t mode;
    status_t    err;
    status_t    status_acc;
    status_t    final_status;
    kind_t      kind;
    logic [4:0] count;

    assign push = item_valid && !q_full;

    always_comb
    begin
        for (int i = 0; i < MAX_THRUSTERS; i++)
        begin
            modes[i] = mode_map[MODE_W*i +: MODE_W];
        end
        mode = modes[position_reg[MODE_SEL_W-1:0]];

        err  = STATUS_OK;
        kind = KIND_ZERO;
        if (mode >= MODE_POSITION)
        begin
            err = STATUS_MODE;
        end
        else if (!value_present)
        begin
            err = STATUS_UNSET;
        end
        else if (mode == MODE_EFFORT)
        begin
            kind = KIND_EFFORT;
        end
        else
        begin
            kind = KIND_QUAD;
        end

        // first error of the sample sticks
        status_acc = (pending_reg == STATUS_OK) ? err : pending_reg;
        count      = {1'b0, position_reg} + 5'd1;
        if (count != {1'b0, thruster_count} || count > 5'(MAX_THRUSTERS))
        begin
            final_status = STATUS_COUNT;
        end
        else
        begin
            final_status = status_acc;
        end
    end

    always_comb
    begin
        push_entry.kind   = kind;
        push_entry.raw    = (mode == MODE_RAW);
        push_entry.cmd    = command_value;
        // sign of the drive value follows the command
        push_entry.coeff  = (command_value > 16'sd0) ? coeff_positive : coeff_negative;
        push_entry.col    = {col_yaw, col_pitch, col_roll, col_heave, col_sway, col_surge};
        push_entry.last   = last_thruster;
        push_entry.status = last_thruster ? final_status : STATUS_OK;
    end

    always_comb
    begin
        position_next = position_reg;
        pending_next  = pending_reg;
        if (push)
        begin
            if (last_thruster)
            begin
                position_next = '0;
                pending_next  = STATUS_OK;
            end
            else
            begin
                position_next = (position_reg == 4'hF) ? position_reg : position_reg + 4'd1;
                pending_next  = status_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            pending_reg  <= STATUS_OK;
        end
        else
        begin
            position_reg <= position_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfa_queue.sv =====
// Short queue of classified beats between front and back end.
`default_nettype none

module tfa_queue
    import tfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire tfa_entry_t  push_entry,
    input  wire logic        pop,
    output logic             full,
    output tfa_head_t        head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tfa_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfa_back.sv =====
// Back end: force sequencer, six axis lanes, saturating sums and result register.
`default_nettype none

module tfa_back
    import tfa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tfa_head_t                 head,
    output logic                           pop,
    input  wire logic [15:0]               supply_voltage,
    input  wire logic [7:0]                dead_band,
    input  wire logic                      result_stall,
    output logic                           result_valid,
    output logic signed [FORCE_W-1:0]      thruster_effort,
    output logic signed [SUM_W-1:0]        surge_force,
    output logic signed [SUM_W-1:0]        sway_force,
    output logic signed [SUM_W-1:0]        heave_force,
    output logic signed [SUM_W-1:0]        roll_torque,
    output logic signed [SUM_W-1:0]        pitch_torque,
    output logic signed [SUM_W-1:0]        yaw_torque,
    output status_t                        sample_status,
    output logic                           sample_done
);

    localparam int PROD_W = FORCE_W + DATA_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    be_state_t state_reg, state_next;

    tfa_entry_t                 entry_reg, entry_next;
    logic signed [32:0]         x_reg, x_next;
    logic [30:0]                mag_reg, mag_next;
    logic [15:0]                cmag_reg, cmag_next;
    logic                       neg_reg, neg_next;
    logic [61:0]                sq_reg, sq_next;
    logic [46:0]                plo_reg, plo_next;
    logic [46:0]                phi_reg, phi_next;
    logic signed [FORCE_W-1:0]  force_reg, force_next;
    logic signed [PROD_W-1:0]   prod_reg [AXES];
    logic signed [PROD_W-1:0]   prod_next [AXES];
    logic signed [SUM_W-1:0]    sums_reg [AXES];
    logic signed [SUM_W-1:0]    sums_next [AXES];
    logic signed [SUM_W-1:0]    sout_reg [AXES];
    logic signed [SUM_W-1:0]    sout_next [AXES];
    logic                       valid_reg, valid_next;
    logic signed [FORCE_W-1:0]  effort_reg, effort_next;
    status_t                    status_reg, status_next;
    logic                       done_reg, done_next;

    // shared arithmetic
    logic [16:0]                scale;
    logic signed [32:0]         scale_prod;
    logic [32:0]                x_abs;
    logic                       in_band;
    logic [30:0]                mul_op;
    logic [46:0]                coef_prod;
    logic [53:0]                quad_mag;
    logic signed [SUM_W:0]      acc [AXES];
    logic signed [SUM_W-1:0]    acc_sat [AXES];
    logic                       out_free;

    assign out_free = !valid_reg || !result_stall;
    assign pop      = (state_reg == BE_IDLE) && head.valid;

    always_comb
    begin
        scale      = entry_reg.raw ? {1'b0, supply_voltage} : 17'd256;
        scale_prod = entry_reg.cmd * $signed(scale);
        x_abs      = x_reg[32] ? 33'(-x_reg) : x_reg;
        in_band    = (x_abs <= {17'b0, dead_band, 8'b0});
        mul_op     = (state_reg == BE_MUL_HI) ? sq_reg[61:31] : sq_reg[30:0];
        coef_prod  = cmag_reg * mul_op;
        // floor(|c| * x^2 / 2^24) from the two partial products
        quad_mag   = {phi_reg, 7'b0} + {31'b0, plo_reg[46:24]};
        for (int k = 0; k < AXES; k++)
        begin
            acc[k] = {sums_reg[k][SUM_W-1], sums_reg[k]}
                   + {prod_reg[k][PROD_W-1], prod_reg[k][PROD_W-1:8]};
            if (acc[k][SUM_W] != acc[k][SUM_W-1])
            begin
                acc_sat[k] = acc[k][SUM_W] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                acc_sat[k] = acc[k][SUM_W-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.entry.kind == KIND_QUAD) ? BE_SCALE : BE_AXIS_MUL;
                end
            end
            BE_SCALE:    state_next = BE_CHECK;
            BE_CHECK:    state_next = in_band ? BE_AXIS_MUL : BE_SQUARE;
            BE_SQUARE:   state_next = BE_MUL_LO;
            BE_MUL_LO:   state_next = BE_MUL_HI;
            BE_MUL_HI:   state_next = BE_SAT;
            BE_SAT:      state_next = BE_AXIS_MUL;
            BE_AXIS_MUL: state_next = BE_AXIS_ACC;
            BE_AXIS_ACC:
            begin
                if (out_free)
                begin
                    state_next = BE_IDLE;
                end
            end
            default:     state_next = BE_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        entry_next  = entry_reg;
        x_next      = x_reg;
        mag_next    = mag_reg;
        cmag_next   = cmag_reg;
        neg_next    = neg_reg;
        sq_next     = sq_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        force_next  = force_reg;
        prod_next   = prod_reg;
        sums_next   = sums_reg;
        sout_next   = sout_reg;
        effort_next = effort_reg;
        status_next = status_reg;
        done_next   = done_reg;
        valid_next  = valid_reg && result_stall;

        case (state_reg)
            BE_IDLE:
            begin
                if (head.valid)
                begin
                    entry_next = head.entry;
                    if (head.entry.kind == KIND_EFFORT)
                    begin
                        force_next = {{8{head.entry.cmd[DATA_W-1]}}, head.entry.cmd, 8'b0};
                    end
                    else
                    begin
                        force_next = '0;
                    end
                end
            end
            BE_SCALE:
            begin
                x_next = scale_prod;
            end
            BE_CHECK:
            begin
                mag_next  = x_abs[30:0];
                cmag_next = entry_reg.coeff[DATA_W-1] ? 16'(-entry_reg.coeff)
                                                      : 16'(entry_reg.coeff);
                neg_next  = entry_reg.coeff[DATA_W-1] ^ x_reg[32];
                force_next = '0;
            end
            BE_SQUARE:
            begin
                sq_next = mag_reg * mag_reg;
            end
            BE_MUL_LO:
            begin
                plo_next = coef_prod;
            end
            BE_MUL_HI:
            begin
                phi_next = coef_prod;
            end
            BE_SAT:
            begin
                if (neg_reg)
                begin
                    force_next = (quad_mag >= 54'h8000_0000) ? 32'sh8000_0000
                                                             : 32'(-quad_mag[31:0]);
                end
                else
                begin
                    force_next = (quad_mag >= 54'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                             : 32'(quad_mag[31:0]);
                end
            end
            BE_AXIS_MUL:
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    prod_next[k] = force_reg * $signed(entry_reg.col[k]);
                end
            end
            BE_AXIS_ACC:
            begin
                if (out_free)
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        if (entry_reg.last)
                        begin
                            sout_next[k] = acc_sat[k];
                            sums_next[k] = '0;
                        end
                        else
                        begin
                            sout_next[k] = '0;
                            sums_next[k] = acc_sat[k];
                        end
                    end
                    effort_next = force_reg;
                    status_next = entry_reg.status;
                    done_next   = entry_reg.last;
                    valid_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        x_reg      <= x_next;
        mag_reg    <= mag_next;
        cmag_reg   <= cmag_next;
        neg_reg    <= neg_next;
        sq_reg     <= sq_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        force_reg  <= force_next;
        prod_reg   <= prod_next;
        sout_reg   <= sout_next;
        effort_reg <= effort_next;
        status_reg <= status_next;
        done_reg   <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            sums_reg  <= sums_next;
        end
    end

    assign result_valid    = valid_reg;
    assign thruster_effort = effort_reg;
    assign surge_force     = sout_reg[0];
    assign sway_force      = sout_reg[1];
    assign heave_force     = sout_reg[2];
    assign roll_torque     = sout_reg[3];
    assign pitch_torque    = sout_reg[4];
    assign yaw_torque      = sout_reg[5];
    assign sample_status   = status_reg;
    assign sample_done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/thruster_force_allocation.sv =====
// Top level of the thruster force allocation block: registers, front, queue, back end.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  item      | item_valid / item_stall    | command, presence, coefficients, column,
//            |                            | last_thruster
//  result    | result_valid / result_stall| thruster_effort, six body sums, status,
//            |                            | sample_done
//  config    | wr_en, wr_index            | wr_data (widest register, 24 bits)
//
// Effort or error thrusters go from idle straight to the axis multiply and accumulate
// steps; on the quadratic path a beat passes scale and deadband check first, then, outside
// the deadband, square, low and high coefficient multiply (one shared 16x31 multiplier), saturate.
// The front accepts a beat per cycle until the two-entry queue is full.
// Reset (async, active low) restores register defaults and clears sums, position
// and status.
// A stalled result holds the back end in its accumulate step; the queue keeps
// taking beats meanwhile until it is full.
`default_nettype none

module thruster_force_allocation
    import tfa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration
    input  wire logic                     wr_en,
    input  wire reg_index_t               wr_index,
    input  wire logic [23:0]              wr_data,
    // thruster beats
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic signed [DATA_W-1:0] command_value,
    input  wire logic                     value_present,
    input  wire logic signed [DATA_W-1:0] coeff_positive,
    input  wire logic signed [DATA_W-1:0] coeff_negative,
    input  wire logic signed [DATA_W-1:0] col_surge,
    input  wire logic signed [DATA_W-1:0] col_sway,
    input  wire logic signed [DATA_W-1:0] col_heave,
    input  wire logic signed [DATA_W-1:0] col_roll,
    input  wire logic signed [DATA_W-1:0] col_pitch,
    input  wire logic signed [DATA_W-1:0] col_yaw,
    input  wire logic                     last_thruster,
    // results
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [FORCE_W-1:0]     thruster_effort,
    output logic signed [SUM_W-1:0]       surge_force,
    output logic signed [SUM_W-1:0]       sway_force,
    output logic signed [SUM_W-1:0]       heave_force,
    output logic signed [SUM_W-1:0]       roll_torque,
    output logic signed [SUM_W-1:0]       pitch_torque,
    output logic signed [SUM_W-1:0]       yaw_torque,
    output status_t                       sample_status,
    output logic                          sample_done
);

    // configuration registers, to be written only while idle; the block does not enforce it
    logic [3:0]  thruster_count_reg;
    logic [23:0] mode_map_reg;
    logic [15:0] supply_voltage_reg;
    logic [7:0]  dead_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thruster_count_reg <= THRUSTER_COUNT_RST;
            mode_map_reg       <= MODE_MAP_RST;
            supply_voltage_reg <= SUPPLY_VOLTAGE_RST;
            dead_band_reg      <= DEAD_BAND_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_THRUSTER_COUNT: thruster_count_reg <= wr_data[3:0];
                REG_MODE_MAP:       mode_map_reg       <= wr_data;
                REG_SUPPLY_VOLTAGE: supply_voltage_reg <= wr_data[15:0];
                REG_DEAD_BAND:      dead_band_reg      <= wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    tfa_entry_t q_entry;
    tfa_head_t  q_head;

    assign item_stall = q_full;

    // front: position count, mode lookup, status tracking
    tfa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .q_full         (q_full),
        .command_value  (command_value),
        .value_present  (value_present),
        .coeff_positive (coeff_positive),
        .coeff_negative (coeff_negative),
        .col_surge      (col_surge),
        .col_sway       (col_sway),
        .col_heave      (col_heave),
        .col_roll       (col_roll),
        .col_pitch      (col_pitch),
        .col_yaw        (col_yaw),
        .last_thruster  (last_thruster),
        .thruster_count (thruster_count_reg),
        .mode_map       (mode_map_reg),
        .push           (q_push),
        .push_entry     (q_entry)
    );

    tfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head       (q_head)
    );

    // back: force computation, axis lanes, sums and result register
    tfa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .pop             (q_pop),
        .supply_voltage  (supply_voltage_reg),
        .dead_band       (dead_band_reg),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .thruster_effort (thruster_effort),
        .surge_force     (surge_force),
        .sway_force      (sway_force),
        .heave_force     (heave_force),
        .roll_torque     (roll_torque),
        .pitch_torque    (pitch_torque),
        .yaw_torque      (yaw_torque),
        .sample_status   (sample_status),
        .sample_done     (sample_done)
    );

`ifndef NO_ASSERTIONS
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_head.valid)
        else $error("queue full but head not valid");

    a_one_pop_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back end took two beats in consecutive cycles");

    a_partial_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !sample_done |->
            surge_force == '0 && sway_force == '0 && heave_force == '0 &&
            roll_torque == '0 && pitch_torque == '0 && yaw_torque == '0 &&
            sample_status == STATUS_OK)
        else $error("sums or status set on a beat that does not end a sample");
`endif

endmodule

`default_nettype wire

// ===== dv/thruster_force_allocation_tb.sv =====
// Self-checking testbench for the thruster force allocation block.
`default_nettype none

module thruster_force_allocation_tb;
    import tfa_pkg::*;

    // Mode codes that the package leaves unnamed; all of them are unsupported.
    localparam mode_code_t MODE_ACCEL = 3'd4;
    localparam mode_code_t MODE_RSV5  = 3'd5;
    localparam mode_code_t MODE_RSV6  = 3'd6;
    localparam mode_code_t MODE_RSV7  = 3'd7;

    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -64'sd549755813888;

    localparam int RANDOM_BEATS = 1550;

    // One thruster beat as the sender sees it.
    typedef struct packed {
        logic signed [DATA_W-1:0]    cmd;
        logic                        present;
        logic signed [DATA_W-1:0]    cpos;
        logic signed [DATA_W-1:0]    cneg;
        logic [AXES-1:0][DATA_W-1:0] col;   // surge, sway, heave, roll, pitch, yaw
        logic                        last;
    } beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [FORCE_W-1:0]   effort;
        logic [AXES-1:0][SUM_W-1:0]  sums;
        status_t                     status;
        logic                        done;
    } result_t;

    // ------------------------------------------------------------------
    // Scoreboard: shadow registers and sample state, plus the queue of
    // results still owed by the block.
    // ------------------------------------------------------------------
    class force_scoreboard;
        logic [3:0]  count_reg;
        logic [23:0] mode_map;
        logic [15:0] voltage;
        logic [7:0]  dead_band;

        int unsigned position;
        longint      sums [AXES];
        status_t     pending;

        result_t     owed [$];

        int errors;
        int checked;
        int beats;
        int samples;
        int status_seen [4];

        function new();
            count_reg = THRUSTER_COUNT_RST;
            mode_map  = MODE_MAP_RST;
            voltage   = SUPPLY_VOLTAGE_RST;
            dead_band = DEAD_BAND_RST;
            position  = 0;
            foreach (sums[k]) sums[k] = 0;
            pending   = STATUS_OK;
            errors    = 0;
            checked   = 0;
            beats     = 0;
            samples   = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [23:0] d);
            case (idx)
                REG_THRUSTER_COUNT: count_reg = d[3:0];
                REG_MODE_MAP:       mode_map  = d[23:0];
                REG_SUPPLY_VOLTAGE: voltage   = d[15:0];
                REG_DEAD_BAND:      dead_band = d[7:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // |coeff| * x * x brought down to Q16.16 by dropping 24 bits, then signed
        // and clamped to 32 bits.
        function longint quad_term(longint coeff, longint x);
            bit [63:0] m;
            bit [63:0] c;
            bit [63:0] sq;
            bit [63:0] mag;
            bit        neg;
            m   = (x < 0) ? -x : x;
            c   = (coeff < 0) ? -coeff : coeff;
            sq  = m * m;
            mag = ((c * (sq >> 32)) << 8) + ((c * (sq & 64'hFFFF_FFFF)) >> 24);
            neg = (coeff < 0) != (x < 0);
            if (mag == 0)
                return 0;
            if (neg)
                return (mag >= 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
            return (mag >= 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
        endfunction

        // Accepted input beat: work out the force, fold it into the body sums
        // and queue the result this beat must produce.
        function void note_beat(beat_t b);
            longint      cmdv;
            longint      x;
            longint      db;
            longint      frc;
            longint      s;
            int unsigned pos;
            int unsigned cnt;
            mode_code_t  mode;
            status_t     err;
            status_t     st;
            result_t     r;
            cmdv = b.cmd;
            pos  = position;
            mode = mode_map[3 * (pos % 8) +: 3];
            err  = STATUS_OK;
            frc  = 0;
            if (mode >= MODE_POSITION)
                err = STATUS_MODE;
            else if (!b.present)
                err = STATUS_UNSET;
            else if (mode == MODE_EFFORT)
                frc = cmdv * 256;
            else
            begin
                x  = (mode == MODE_RAW) ? cmdv * longint'(voltage) : cmdv * 256;
                db = longint'(dead_band) * 256;
                // deadband edge is inclusive
                if (x < -db || x > db)
                    frc = quad_term((x > 0) ? longint'(b.cpos) : longint'(b.cneg), x);
            end
            if (pending == STATUS_OK)
                pending = err;

            // Q24.24 axis term to Q24.16, floor rounding, saturating sum
            for (int k = 0; k < AXES; k++)
            begin
                s = sums[k] + ((frc * longint'($signed(b.col[k]))) >>> 8);
                if (s > SUM_MAX) s = SUM_MAX;
                if (s < SUM_MIN) s = SUM_MIN;
                sums[k] = s;
            end

            r.effort = frc[FORCE_W-1:0];
            beats++;
            if (b.last)
            begin
                cnt = pos + 1;
                st  = pending;
                if (cnt != count_reg || cnt > MAX_THRUSTERS)
                    st = STATUS_COUNT;
                for (int k = 0; k < AXES; k++)
                begin
                    r.sums[k] = sums[k][SUM_W-1:0];
                    sums[k]   = 0;
                end
                r.status = st;
                r.done   = 1'b1;
                position = 0;
                pending  = STATUS_OK;
                samples++;
                status_seen[st]++;
            end
            else
            begin
                r.sums   = '0;
                r.status = STATUS_OK;
                r.done   = 1'b0;
                if (pos < 15)
                    position = pos + 1;
            end
            owed.insert(owed.size(), r);
        endfunction

        function void compare(string what, longint e, longint a);
            if (e != a)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on %s at result %0d: expected %0d, got %0d",
                             what, checked, e, a);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing owed: effort %0d done %0b",
                             got.effort, got.done);
                return;
            end
            e = owed.pop_front();
            compare("thruster_effort", e.effort, got.effort);
            for (int k = 0; k < AXES; k++)
                compare($sformatf("body sum %0d", k), $signed(e.sums[k]),
                        $signed(got.sums[k]));
            compare("sample_status", e.status, got.status);
            compare("sample_done", e.done, got.done);
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    logic                     wr_en          = 1'b0;
    reg_index_t               wr_index       = REG_THRUSTER_COUNT;
    logic [23:0]              wr_data        = '0;
    logic                     item_valid     = 1'b0;
    logic                     item_stall;
    logic signed [DATA_W-1:0] command_value  = '0;
    logic                     value_present  = 1'b0;
    logic signed [DATA_W-1:0] coeff_positive = '0;
    logic signed [DATA_W-1:0] coeff_negative = '0;
    logic signed [DATA_W-1:0] col_surge      = '0;
    logic signed [DATA_W-1:0] col_sway       = '0;
    logic signed [DATA_W-1:0] col_heave      = '0;
    logic signed [DATA_W-1:0] col_roll       = '0;
    logic signed [DATA_W-1:0] col_pitch      = '0;
    logic signed [DATA_W-1:0] col_yaw        = '0;
    logic                     last_thruster  = 1'b0;
    logic                     result_valid;
    logic                     result_stall   = 1'b0;
    logic signed [FORCE_W-1:0] thruster_effort;
    logic signed [SUM_W-1:0]  surge_force;
    logic signed [SUM_W-1:0]  sway_force;
    logic signed [SUM_W-1:0]  heave_force;
    logic signed [SUM_W-1:0]  roll_torque;
    logic signed [SUM_W-1:0]  pitch_torque;
    logic signed [SUM_W-1:0]  yaw_torque;
    status_t                  sample_status;
    logic                     sample_done;

    thruster_force_allocation u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command_value  (command_value),
        .value_present  (value_present),
        .coeff_positive (coeff_positive),
        .coeff_negative (coeff_negative),
        .col_surge      (col_surge),
        .col_sway       (col_sway),
        .col_heave      (col_heave),
        .col_roll       (col_roll),
        .col_pitch      (col_pitch),
        .col_yaw        (col_yaw),
        .last_thruster  (last_thruster),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .thruster_effort(thruster_effort),
        .surge_force    (surge_force),
        .sway_force     (sway_force),
        .heave_force    (heave_force),
        .roll_torque    (roll_torque),
        .pitch_torque   (pitch_torque),
        .yaw_torque     (yaw_torque),
        .sample_status  (sample_status),
        .sample_done    (sample_done)
    );

    force_scoreboard sb = new();

    // When set, neither side inserts gaps or stalls (back-to-back stretch).
    bit no_idle = 1'b0;
    int settings_used = 0;

    // ------------------------------------------------------------------
    // Driver tasks. All are entered right after a rising edge and return
    // right after one; inputs change only by NBA at the edge.
    // ------------------------------------------------------------------

    // Send one beat: random gap, then hold valid and payload until accepted.
    task automatic send_beat(beat_t b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        command_value  <= b.cmd;
        value_present  <= b.present;
        coeff_positive <= b.cpos;
        coeff_negative <= b.cneg;
        col_surge      <= b.col[0];
        col_sway       <= b.col[1];
        col_heave      <= b.col[2];
        col_roll       <= b.col[3];
        col_pitch      <= b.col[4];
        col_yaw        <= b.col[5];
        last_thruster  <= b.last;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        sb.note_beat(b);
    endtask

    // Stop sending and wait until every owed result is back, plus a margin
    // for the back end to settle before registers move.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write all four registers back to back; only called while idle.
    task automatic configure(logic [3:0] cnt, logic [23:0] map, logic [15:0] volt,
                             logic [7:0] db);
        logic [23:0] vals [4];
        reg_index_t  idx  [4];
        vals = '{{20'd0, cnt}, map, {8'd0, volt}, {16'd0, db}};
        idx  = '{REG_THRUSTER_COUNT, REG_MODE_MAP, REG_SUPPLY_VOLTAGE, REG_DEAD_BAND};
        for (int i = 0; i < 4; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(idx[i], vals[i]);
        end
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mix of extremes, values around the deadband edge and full-range noise.
    function automatic logic [15:0] pick_word();
        int r;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 8)  return 16'h7FFF;
        if (r < 16) return 16'h8000;
        if (r < 19) return 16'h0000;
        if (r < 45)
        begin
            v = 16'($urandom_range(0, 600));
            return v - 16'd300;
        end
        v = 16'($urandom);
        return v;
    endfunction

    function automatic beat_t rand_beat(logic last);
        beat_t b;
        b.cmd     = pick_word();
        b.present = ($urandom_range(0, 99) < 92);
        b.cpos    = pick_word();
        b.cneg    = pick_word();
        for (int k = 0; k < AXES; k++)
            b.col[k] = pick_word();
        b.last    = last;
        return b;
    endfunction

    function automatic beat_t make_beat(logic [15:0] cmd, logic present, logic [15:0] cpos,
                                        logic [15:0] cneg, logic [15:0] colv, logic last);
        beat_t b;
        b.cmd     = cmd;
        b.present = present;
        b.cpos    = cpos;
        b.cneg    = cneg;
        for (int k = 0; k < AXES; k++)
            b.col[k] = colv;
        b.last    = last;
        return b;
    endfunction

    // Mostly supported modes; roughly one field in six is unsupported.
    function automatic logic [23:0] rand_mode_map();
        logic [23:0] map;
        int r;
        for (int p = 0; p < MAX_THRUSTERS; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)      map[3*p +: 3] = MODE_EFFORT;
            else if (r < 52) map[3*p +: 3] = MODE_SPEED;
            else if (r < 84) map[3*p +: 3] = MODE_RAW;
            else             map[3*p +: 3] = mode_code_t'($urandom_range(3, 7));
        end
        return map;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each accepted beat, then draw the next stall run.
    // ------------------------------------------------------------------
    initial
    begin
        result_t got;
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                got.effort  = thruster_effort;
                got.sums[0] = surge_force;
                got.sums[1] = sway_force;
                got.sums[2] = heave_force;
                got.sums[3] = roll_torque;
                got.sums[4] = pitch_torque;
                got.sums[5] = yaw_torque;
                got.status  = sample_status;
                got.done    = sample_done;
                sb.check_result(got);
                hold = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                hold--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: well beyond the slowest legal run of this stimulus.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        beat_t b;
        int random_beats;
        int phase_beats;
        int phase;
        int len;
        logic [3:0]  cnt;
        logic [15:0] volt;
        logic [7:0]  db;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: six thrusters, all raw, unity voltage, deadband 3.
        // Extremes, both sides of the inclusive deadband edge, an unset value.
        send_beat(make_beat(16'h7FFF, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
        send_beat(make_beat(16'h8000, 1'b1, 16'h7FFF, 16'h8000, 16'h8000, 1'b0));
        send_beat(make_beat(16'd3,    1'b1, 16'h7FFF, 16'h8000, 16'h0100, 1'b0));
        send_beat(make_beat(16'd4,    1'b1, 16'h8000, 16'h7FFF, 16'hFF00, 1'b0));
        send_beat(make_beat(16'hFFFD, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 1'b0));
        send_beat(make_beat(16'h0000, 1'b0, 16'h1234, 16'hEDCB, 16'h7FFF, 1'b1));
        drain();
        settings_used++;

        // One thruster per mode code, max voltage and deadband; a raw command
        // of 1 lands just outside the deadband. Unsupported mode with unset
        // value must still report the mode error.
        configure(4'd8, {MODE_RSV7, MODE_RSV6, MODE_RSV5, MODE_ACCEL,
                         MODE_POSITION, MODE_RAW, MODE_SPEED, MODE_EFFORT},
                  16'hFFFF, 8'hFF);
        send_beat(make_beat(16'h7FFF, 1'b1, 16'h0100, 16'h0100, 16'h7FFF, 1'b0));
        send_beat(make_beat(16'h8000, 1'b1, 16'h0100, 16'h8000, 16'h8000, 1'b0));
        send_beat(make_beat(16'd1,    1'b1, 16'h7FFF, 16'h8000, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0200, 1'b0, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0200, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0200, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0200, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0200, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b1));
        // Short sample: count mismatch wins over the unset value on beat 0.
        send_beat(make_beat(16'h0100, 1'b0, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0100, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        send_beat(make_beat(16'h0100, 1'b1, 16'h0100, 16'h0100, 16'h0100, 1'b1));
        drain();

        // All speed, zero voltage and deadband: full-scale forces drive the
        // sums into both saturation limits; a zero command sits on the edge.
        configure(4'd8, {8{MODE_SPEED}}, 16'h0000, 8'h00);
        for (int i = 0; i < 8; i++)
        begin
            b = make_beat((i == 7) ? 16'h0000 : ((i % 2) ? 16'h8000 : 16'h7FFF), 1'b1,
                          16'h7FFF, 16'h8000, 16'h7FFF, i == 7);
            b.col[1] = 16'h8000;
            b.col[3] = 16'h8000;
            b.col[5] = 16'h0000;
            send_beat(b);
        end
        drain();

        // Random phases: new register set each time, then mostly well-formed
        // samples with random content, some of odd length (over 16 hits the
        // position saturation).
        random_beats = 0;
        phase = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            case (phase % 5)
                0: cnt = 4'd1;
                1: cnt = 4'd8;
                4: cnt = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
                default: cnt = 4'($urandom_range(1, 8));
            endcase
            case (phase % 4)
                0: volt = 16'h0000;
                1: volt = 16'hFFFF;
                2: volt = 16'h0100;
                default: volt = 16'($urandom);
            endcase
            case (phase % 3)
                0: db = 8'h00;
                1: db = 8'hFF;
                default: db = 8'($urandom);
            endcase
            configure(cnt, rand_mode_map(), volt, db);
            no_idle = (phase == 3);

            phase_beats = 0;
            while (phase_beats < 150)
            begin
                if (cnt >= 1 && cnt <= MAX_THRUSTERS && $urandom_range(0, 99) < 85)
                    len = cnt;
                else
                    len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_beat(rand_beat(i == len - 1));
                phase_beats += len;
            end
            random_beats += phase_beats;
            no_idle = 1'b0;
            drain();
            phase++;
        end

        $display("checked %0d results from %0d beats in %0d samples over %0d register sets",
                 sb.checked, sb.beats, sb.samples, settings_used);
        $display("sample status: ok %0d, count %0d, unset %0d, mode %0d; mismatches %0d",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_COUNT],
                 sb.status_seen[STATUS_UNSET], sb.status_seen[STATUS_MODE], sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
